[rtl/rgbls_pkg.sv]
package rgbls_pkg;

   // Sizing of the sequencer.
   localparam int MAX_STEPS  = 16;
   localparam int LEVEL_BITS = 16;
   localparam int TICK_BITS  = 12;

   localparam int STEP_BITS = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int LEN_BITS  = $clog2(MAX_STEPS + 1);
   localparam int TICK_MAX  = (1 << TICK_BITS) - 1;

   // Field widths fixed by the word layout.
   localparam int ACT_BITS   = 3;
   localparam int IDX_BITS   = 4;
   localparam int INC_BITS   = 16;
   localparam int DUR_BITS   = 13;
   localparam int TOTAL_BITS = 5;
   localparam int CH_BITS    = 2;
   localparam int VAL_BITS   = 16;
   localparam int OUT_BITS   = 16;
   localparam int CUR_BITS   = 4;
   localparam int NUM_CH     = 3;

   typedef enum logic [ACT_BITS-1:0] {
      ACT_TICK  = 3'd0,
      ACT_WRITE = 3'd1,
      ACT_START = 3'd2,
      ACT_STOP  = 3'd3,
      ACT_LEVEL = 3'd4
   } action_type;

   localparam logic [CH_BITS-1:0] CH_RED   = 2'd0;
   localparam logic [CH_BITS-1:0] CH_GREEN = 2'd1;
   localparam logic [CH_BITS-1:0] CH_BLUE  = 2'd2;

   // Duration code that ends a pattern (minus one).
   localparam logic [DUR_BITS-1:0] DUR_END = '1;

   // One pattern step as held in the store; inc[0] is red, inc[2] is blue.
   typedef struct packed {
      logic [DUR_BITS-1:0]            dur;
      logic [NUM_CH-1:0][INC_BITS-1:0] inc;
   } step_type;

   typedef struct packed {
      logic                 en;
      logic [STEP_BITS-1:0] addr;
      step_type             data;
   } store_wr_type;

   typedef struct packed {
      logic [ACT_BITS-1:0]             action;
      logic [IDX_BITS-1:0]             step_index;
      logic [NUM_CH-1:0][INC_BITS-1:0] inc;
      logic [DUR_BITS-1:0]             step_ticks;
      logic [TOTAL_BITS-1:0]           step_total;
      logic [CH_BITS-1:0]              channel;
      logic [VAL_BITS-1:0]             level_value;
   } item_type;

   typedef struct packed {
      logic                playing;
      logic [CUR_BITS-1:0] current_step;
      logic                blue_enable;
      logic                green_enable;
      logic                red_enable;
      logic [OUT_BITS-1:0] blue_level;
      logic [OUT_BITS-1:0] green_level;
      logic [OUT_BITS-1:0] red_level;
   } result_type;

endpackage

[rtl/rgbls_store.sv]
// Pattern store: one write port, one read port with registered data.
// A write to the entry being read in the same cycle is forwarded.
module rgbls_store (
   input  logic                          clock,
   input  rgbls_pkg::store_wr_type       wr,
   input  logic [rgbls_pkg::STEP_BITS-1:0] rd_addr,
   output rgbls_pkg::step_type           rd_data_ff
);

   rgbls_pkg::step_type mem [rgbls_pkg::MAX_STEPS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[rtl/rgbls_engine.sv]
// Playback state and the per-word update. The store is always read at the
// pointer value of the next cycle, so the current step is ready on every edge.
module rgbls_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   input  rgbls_pkg::item_type             item,
   input  rgbls_pkg::step_type             entry,
   output logic [rgbls_pkg::STEP_BITS-1:0] rd_addr,
   output rgbls_pkg::store_wr_type         wr,
   output rgbls_pkg::result_type           result
);

   logic [rgbls_pkg::LEN_BITS-1:0]   len_ff,  len_in;
   logic [rgbls_pkg::STEP_BITS-1:0]  ptr_ff,  ptr_in;
   logic [rgbls_pkg::TICK_BITS-1:0]  tick_ff, tick_in;
   logic [rgbls_pkg::LEVEL_BITS-1:0] lvl_ff [rgbls_pkg::NUM_CH];
   logic [rgbls_pkg::LEVEL_BITS-1:0] lvl_in [rgbls_pkg::NUM_CH];
   logic [rgbls_pkg::NUM_CH-1:0]     en_ff,   en_in;
   logic                             play_ff, play_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         ptr_ff  <= '0;
         tick_ff <= '0;
         en_ff   <= '0;
         play_ff <= 1'b0;
         for (int c = 0; c < rgbls_pkg::NUM_CH; c++) begin
            lvl_ff[c] <= '0;
         end
      end else begin
         len_ff  <= len_in;
         ptr_ff  <= ptr_in;
         tick_ff <= tick_in;
         en_ff   <= en_in;
         play_ff <= play_in;
         for (int c = 0; c < rgbls_pkg::NUM_CH; c++) begin
            lvl_ff[c] <= lvl_in[c];
         end
      end
   end

   always_comb begin
      logic [rgbls_pkg::TICK_BITS-1:0]  dur_eff;
      logic [rgbls_pkg::TICK_BITS:0]    cnt;
      logic [rgbls_pkg::LEN_BITS-1:0]   nxt;
      logic [rgbls_pkg::LEVEL_BITS-1:0] val;

      len_in  = len_ff;
      ptr_in  = ptr_ff;
      tick_in = tick_ff;
      en_in   = en_ff;
      play_in = play_ff;
      for (int c = 0; c < rgbls_pkg::NUM_CH; c++) begin
         lvl_in[c] = lvl_ff[c];
      end
      wr = '0;

      // Zero and negative durations act as one tick; large ones saturate.
      if (entry.dur[rgbls_pkg::DUR_BITS-1] || (entry.dur == '0)) begin
         dur_eff = rgbls_pkg::TICK_BITS'(1);
      end else if (int'(entry.dur) > rgbls_pkg::TICK_MAX) begin
         dur_eff = rgbls_pkg::TICK_BITS'(rgbls_pkg::TICK_MAX);
      end else begin
         dur_eff = rgbls_pkg::TICK_BITS'(entry.dur);
      end
      cnt = {1'b0, tick_ff} + 1'b1;
      nxt = rgbls_pkg::LEN_BITS'(ptr_ff) + 1'b1;
      val = item.level_value[rgbls_pkg::LEVEL_BITS-1:0];

      if (item_valid) begin
         case (rgbls_pkg::action_type'(item.action))
            rgbls_pkg::ACT_TICK: begin
               if (play_ff) begin
                  if (entry.dur == rgbls_pkg::DUR_END) begin
                     ptr_in  = '0;
                     tick_in = '0;
                     en_in   = '0;
                     play_in = 1'b0;
                     for (int c = 0; c < rgbls_pkg::NUM_CH; c++) begin
                        lvl_in[c] = '0;
                     end
                  end else begin
                     for (int c = 0; c < rgbls_pkg::NUM_CH; c++) begin
                        lvl_in[c] = lvl_ff[c] + entry.inc[c][rgbls_pkg::LEVEL_BITS-1:0];
                        if (lvl_in[c] != '0) begin
                           en_in[c] = 1'b1;
                        end
                     end
                     if (cnt >= {1'b0, dur_eff}) begin
                        tick_in = '0;
                        if ((nxt >= len_ff) || (int'(nxt) >= rgbls_pkg::MAX_STEPS)) begin
                           ptr_in = '0;
                        end else begin
                           ptr_in = rgbls_pkg::STEP_BITS'(nxt);
                        end
                     end else begin
                        tick_in = cnt[rgbls_pkg::TICK_BITS-1:0];
                     end
                  end
               end
            end
            rgbls_pkg::ACT_WRITE: begin
               if (int'(item.step_index) < rgbls_pkg::MAX_STEPS) begin
                  wr.en       = 1'b1;
                  wr.addr     = rgbls_pkg::STEP_BITS'(item.step_index);
                  wr.data.inc = item.inc;
                  wr.data.dur = item.step_ticks;
               end
            end
            rgbls_pkg::ACT_START: begin
               ptr_in  = '0;
               tick_in = '0;
               en_in   = '0;
               for (int c = 0; c < rgbls_pkg::NUM_CH; c++) begin
                  lvl_in[c] = '0;
               end
               if (int'(item.step_total) > rgbls_pkg::MAX_STEPS) begin
                  len_in = rgbls_pkg::LEN_BITS'(rgbls_pkg::MAX_STEPS);
               end else begin
                  len_in = rgbls_pkg::LEN_BITS'(item.step_total);
               end
               play_in = (item.step_total != '0);
            end
            rgbls_pkg::ACT_STOP: begin
               ptr_in  = '0;
               tick_in = '0;
               en_in   = '0;
               play_in = 1'b0;
               for (int c = 0; c < rgbls_pkg::NUM_CH; c++) begin
                  lvl_in[c] = '0;
               end
            end
            rgbls_pkg::ACT_LEVEL: begin
               for (int c = 0; c < rgbls_pkg::NUM_CH; c++) begin
                  if (item.channel == rgbls_pkg::CH_BITS'(c)) begin
                     lvl_in[c] = val;
                     if (val == '0) begin
                        en_in[c] = 1'b0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Read the entry the pointer will hold after this edge.
   assign rd_addr = ptr_in;

   always_comb begin
      result.red_level    = rgbls_pkg::OUT_BITS'(lvl_in[rgbls_pkg::CH_RED]);
      result.green_level  = rgbls_pkg::OUT_BITS'(lvl_in[rgbls_pkg::CH_GREEN]);
      result.blue_level   = rgbls_pkg::OUT_BITS'(lvl_in[rgbls_pkg::CH_BLUE]);
      result.red_enable   = en_in[rgbls_pkg::CH_RED];
      result.green_enable = en_in[rgbls_pkg::CH_GREEN];
      result.blue_enable  = en_in[rgbls_pkg::CH_BLUE];
      result.current_step = rgbls_pkg::CUR_BITS'(ptr_in);
      result.playing      = play_in;
   end

   // A playing pattern always has steps, and the pointer stays inside it.
   a_play_len: assert property (@(posedge clock) disable iff (reset)
      play_ff |-> (len_ff != '0) && (rgbls_pkg::LEN_BITS'(ptr_ff) < len_ff))
      else $error("pointer outside the pattern while playing");

   // Stopped play leaves the pointer and the tick count cleared.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !play_ff |-> (ptr_ff == '0) && (tick_ff == '0))
      else $error("stale position while stopped");

   // Enables can only rise on a tick during play.
   a_en_rise: assert property (@(posedge clock) disable iff (reset)
      ((en_ff & ~$past(en_ff)) != '0) && !$past(reset) |->
         $past(item_valid) && $past(play_ff) &&
         ($past(item.action) == rgbls_pkg::ACT_TICK))
      else $error("enable set outside a tick");

endmodule

[rtl/rgb_led_pattern_sequencer_top.sv]
// RGB LED pattern sequencer. Request words carry an action in req_tuser
// (tick, write step, start, stop and clear, set level) and its operands in
// req_tdata; every accepted request produces exactly one response word that
// reports the three 16-bit levels, the three channel enables, the step now
// playing and the playing flag as they stand after that request. The block
// takes one request word per clock cycle, sustained, while rsp_tready takes
// every response, and each response appears in the output register in the
// cycle after its request is accepted. That rate is set by the pattern store:
// it is a synchronous memory that is always read at the pointer value that
// the next cycle will use, so the step for a tick is already registered when
// the tick arrives, and a step write that hits the entry being fetched is
// forwarded into the read data. The output register lets a new request in
// while the previous response is being taken; req_tready is low during reset
// and otherwise drops only while that register holds a word that rsp_tready
// refuses. Pattern steps that were never written read as arbitrary values, so
// a pattern must be written before it is started.
module rgb_led_pattern_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0 up: step_index[3:0], inc_red[19:4], inc_green[35:20],
   // inc_blue[51:36], step_ticks[64:52], step_total[69:65], channel[71:70],
   // level_value[87:72].
   input  logic [87:0] req_tdata,
   // Fields from bit 0 up: action[2:0].
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0 up: red_level[15:0], green_level[31:16],
   // blue_level[47:32], red_enable[48], green_enable[49], blue_enable[50],
   // current_step[54:51], playing[55].
   output logic [55:0] rsp_tdata
);

   rgbls_pkg::item_type                 item;
   rgbls_pkg::step_type                 entry;
   rgbls_pkg::store_wr_type             wr;
   rgbls_pkg::result_type               result;
   logic [rgbls_pkg::STEP_BITS-1:0]     rd_addr;
   logic                                accept;
   logic                                rsp_valid_ff, rsp_valid_in;
   rgbls_pkg::result_type               rsp_data_ff;

   // A request is taken when the output register is free or being drained.
   // Nothing is taken while reset is held, since no response could follow.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item.action      = req_tuser;
      item.step_index  = req_tdata[3:0];
      item.inc[0]      = req_tdata[19:4];
      item.inc[1]      = req_tdata[35:20];
      item.inc[2]      = req_tdata[51:36];
      item.step_ticks  = req_tdata[64:52];
      item.step_total  = req_tdata[69:65];
      item.channel     = req_tdata[71:70];
      item.level_value = req_tdata[87:72];
   end

   rgbls_store u_store (
      .clock      (clock),
      .wr         (wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (entry)
   );

   rgbls_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item       (item),
      .entry      (entry),
      .rd_addr    (rd_addr),
      .wr         (wr),
      .result     (result)
   );

   // Output register: holds one response word until it is taken.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
